[rtl/core/sensor_calibration_history_monitor_defines.svh]
// Assertion macros shared by the calibration history monitor RTL.
// Macros assume a clock named clock and a synchronous reset named reset in scope.
`ifndef SENSOR_CALIBRATION_HISTORY_MONITOR_DEFINES_SVH
`define SENSOR_CALIBRATION_HISTORY_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SCSHM_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scshm assertion failed");

// Next-cycle implication, disabled while in reset.
`define SCSHM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scshm assertion failed");

`endif

[rtl/core/scshm_pkg.sv]
// Shared types, constants and helpers of the calibration history monitor.
// No dependencies; every other RTL file of the block but the defines header imports this package.
`timescale 1ns / 1ps

package scshm_pkg;

   // Ring geometry
   localparam int HISTORY_DEPTH = 8;
   localparam int PTR_W         = $clog2(HISTORY_DEPTH);
   localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_INDEX_W   = 3;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CNT_W-1:0] count_type;

   typedef enum logic {
      CMD_CALIBRATE = 1'b0,
      CMD_QUERY     = 1'b1
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_AIR_VOLTAGE_MIN        = 3'd0,
      REG_AIR_VOLTAGE_MAX        = 3'd1,
      REG_MAX_AGE                = 3'd2,
      REG_REPLACEMENT_THRESHOLD  = 3'd3,
      REG_DROP_THRESHOLD         = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [15:0]        air_voltage_min;
      logic [15:0]        air_voltage_max;
      logic [31:0]        max_age;
      logic [15:0]        replacement_threshold;
      logic signed [16:0] drop_threshold;
   } cfg_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [15:0]        air_voltage;
      logic signed [15:0] temperature;
      logic               temperature_valid;
      logic [31:0]        now;
   } req_payload_type;

   typedef struct packed {
      logic               accepted;
      logic               calibrated;
      logic [15:0]        newest_voltage;
      logic signed [15:0] newest_temperature;
      logic               temp_known;
      logic [31:0]        age;
      logic               stale;
      logic               cell_aging;
      logic               declining;
   } rsp_payload_type;

   // Store request from the control stage to the history ring
   typedef struct packed {
      logic            advance;
      logic            write;
      req_payload_type point;
   } ring_ctrl_type;

   // History as it stands after the beat in flight has been stored
   typedef struct packed {
      count_type          count;
      logic [15:0]        oldest_voltage;
      logic [15:0]        newest_voltage;
      logic signed [15:0] newest_temperature;
      logic               newest_temperature_valid;
      logic [31:0]        newest_timestamp;
   } ring_view_type;

   // Ring pointer increment, modulo the depth
   function automatic ptr_type ptr_next(input ptr_type p);
      ptr_type r;
      if (p == PTR_W'(HISTORY_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

[rtl/core/scshm_if.sv]
// Valid/ready channel interfaces for request and response beats.
// Depends on scshm_pkg for the payload types.
`timescale 1ns / 1ps

interface scshm_req_if import scshm_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface scshm_rsp_if import scshm_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/scshm_ring.sv]
// Calibration point history: voltage ring, write pointer, fill count and
// newest/oldest tracking. Depends on scshm_pkg.
`timescale 1ns / 1ps

module scshm_ring import scshm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ring_ctrl_type ctrl,
   output ring_view_type view
);

   // Voltage history; only the oldest entry is ever read back
   logic [15:0] voltage_mem [HISTORY_DEPTH];

   ptr_type            wp_ff, wp_in;
   count_type          count_ff, count_in;
   logic [15:0]        oldest_ff, oldest_in;
   logic [15:0]        ahead_ff;
   ptr_type            rd_addr;
   logic               wr;

   // Newest point kept in flops so it needs no second read port
   logic [15:0]        newest_v_ff, newest_v_in;
   logic signed [15:0] newest_t_ff, newest_t_in;
   logic               newest_tv_ff, newest_tv_in;
   logic [31:0]        newest_ts_ff, newest_ts_in;

   assign wr = ctrl.advance & ctrl.write;

   always_comb begin
      wp_in    = wr ? ptr_next(wp_ff) : wp_ff;
      count_in = count_ff;
      if (wr && (count_ff != CNT_W'(HISTORY_DEPTH))) begin
         count_in = count_ff + 1'b1;
      end

      // Oldest: first point while filling, then the entry the next write evicts
      oldest_in = oldest_ff;
      if (wr) begin
         if (count_ff == '0) begin
            oldest_in = ctrl.point.air_voltage;
         end else if (count_ff == CNT_W'(HISTORY_DEPTH)) begin
            oldest_in = ahead_ff;
         end
      end

      newest_v_in  = wr ? ctrl.point.air_voltage       : newest_v_ff;
      newest_t_in  = wr ? ctrl.point.temperature       : newest_t_ff;
      newest_tv_in = wr ? ctrl.point.temperature_valid : newest_tv_ff;
      newest_ts_in = wr ? ctrl.point.now               : newest_ts_ff;

      // Prefetch the slot after the next write position
      rd_addr = ptr_next(wp_in);
   end

   // Memory write and registered prefetch read, write-first on a collision
   always_ff @(posedge clock) begin
      if (wr) begin
         voltage_mem[wp_ff] <= ctrl.point.air_voltage;
      end
      if (wr && (rd_addr == wp_ff)) begin
         ahead_ff <= ctrl.point.air_voltage;
      end else begin
         ahead_ff <= voltage_mem[rd_addr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         count_ff <= count_in;
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      oldest_ff    <= oldest_in;
      newest_v_ff  <= newest_v_in;
      newest_t_ff  <= newest_t_in;
      newest_tv_ff <= newest_tv_in;
      newest_ts_ff <= newest_ts_in;
   end

   always_comb begin
      view.count                    = count_in;
      view.oldest_voltage           = oldest_in;
      view.newest_voltage           = newest_v_in;
      view.newest_temperature       = newest_t_in;
      view.newest_temperature_valid = newest_tv_in;
      view.newest_timestamp         = newest_ts_in;
   end

endmodule

[rtl/core/scshm_status.sv]
// Status evaluation of one beat from the post-store history view.
// Depends on scshm_pkg.
`timescale 1ns / 1ps

module scshm_status import scshm_pkg::*; (
   input  ring_view_type   view,
   input  cfg_type         cfg,
   input  logic            write,
   input  logic [31:0]     now,
   output rsp_payload_type status
);

   logic               calibrated;
   logic [31:0]        age;
   logic signed [17:0] drop;
   logic signed [17:0] drop_thr;

   always_comb begin
      calibrated = (view.count != '0);
      age        = now - view.newest_timestamp;
      drop       = $signed({2'b00, view.oldest_voltage}) - $signed({2'b00, view.newest_voltage});
      drop_thr   = 18'(cfg.drop_threshold);

      status.accepted   = write;
      status.calibrated = calibrated;
      if (calibrated) begin
         status.newest_voltage     = view.newest_voltage;
         status.temp_known         = view.newest_temperature_valid;
         status.newest_temperature = view.newest_temperature_valid ?
                                     view.newest_temperature : 16'sd0;
         status.age                = age;
         status.stale              = (age >= cfg.max_age);
         status.cell_aging         = (view.newest_voltage <= cfg.replacement_threshold);
         // decline needs an oldest point distinct from the newest
         status.declining          = (view.count >= CNT_W'(2)) && (drop >= drop_thr);
      end else begin
         status.newest_voltage     = '0;
         status.temp_known         = 1'b0;
         status.newest_temperature = 16'sd0;
         status.age                = '1;
         status.stale              = 1'b1;
         status.cell_aging         = 1'b0;
         status.declining          = 1'b0;
      end
   end

endmodule

[rtl/core/sensor_calibration_history_monitor.sv]
// Top level of the sensor calibration history monitor: beat registers,
// configuration registers, history ring and status evaluation.
// Depends on scshm_pkg, scshm_if, scshm_ring, scshm_status and the defines header.
`timescale 1ns / 1ps

`include "sensor_calibration_history_monitor_defines.svh"

// Keeps the last HISTORY_DEPTH calibration points of a gas sensor cell and returns one
// status beat for every request beat, calibrate or query. The block sustains one beat
// per clock while the response side is ready; each beat passes the request register,
// then the response register, and a stalled response holds while one more request
// waits in the request register. Status reflects the history after that beat's own
// store. The user writes the window, age and threshold registers through the csr_ port
// only while no beat is in flight; the block itself does not enforce it. Out-of-range
// voltages are answered but not stored.
module sensor_calibration_history_monitor import scshm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   scshm_req_if.sink              req_bus,
   scshm_rsp_if.source            rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_item_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_item_ff;
   cfg_type         cfg_ff;

   logic            req_fire;
   logic            advance;
   logic            write;
   ring_ctrl_type   ring_ctrl;
   ring_view_type   ring_view;
   rsp_payload_type status;

   // Handshake and stage movement
   assign advance       = in_valid_ff & (~out_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~in_valid_ff | advance;
   assign req_fire      = req_bus.valid & req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Store decision: calibrate beat inside the voltage window
   assign write = (in_item_ff.cmd == CMD_CALIBRATE) &&
                  (in_item_ff.air_voltage >= cfg_ff.air_voltage_min) &&
                  (in_item_ff.air_voltage <= cfg_ff.air_voltage_max);

   always_comb begin
      ring_ctrl.advance = advance;
      ring_ctrl.write   = write;
      ring_ctrl.point   = in_item_ff;
   end

   scshm_ring u_ring (
      .clock (clock),
      .reset (reset),
      .ctrl  (ring_ctrl),
      .view  (ring_view)
   );

   scshm_status u_status (
      .view   (ring_view),
      .cfg    (cfg_ff),
      .write  (write),
      .now    (in_item_ff.now),
      .status (status)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Beat payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_bus.payload;
      end
      if (advance) begin
         out_item_ff <= status;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.air_voltage_min       <= '0;
         cfg_ff.air_voltage_max       <= '1;
         cfg_ff.max_age               <= '1;
         cfg_ff.replacement_threshold <= '0;
         cfg_ff.drop_threshold        <= 17'sd65535;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_AIR_VOLTAGE_MIN:       cfg_ff.air_voltage_min       <= csr_wdata[15:0];
            REG_AIR_VOLTAGE_MAX:       cfg_ff.air_voltage_max       <= csr_wdata[15:0];
            REG_MAX_AGE:               cfg_ff.max_age               <= csr_wdata[31:0];
            REG_REPLACEMENT_THRESHOLD: cfg_ff.replacement_threshold <= csr_wdata[15:0];
            REG_DROP_THRESHOLD:        cfg_ff.drop_threshold        <= $signed(csr_wdata[16:0]);
            default: ;
         endcase
      end
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.payload = out_item_ff;

   // A stored point always leaves the history calibrated
   `SCSHM_ASSERT_NEXT(a_store_calibrates, advance && write, ring_view.count != '0)
   // An uncalibrated response carries the fixed defaults
   `SCSHM_ASSERT_IMPL(a_uncal_defaults, out_valid_ff && !out_item_ff.calibrated, out_item_ff.stale && (out_item_ff.age == '1) && !out_item_ff.declining)
   // A held request beat blocks the request side
   `SCSHM_ASSERT_IMPL(a_hold_blocks, in_valid_ff && !advance, !req_bus.ready)

endmodule
